FILE: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Shared sizes, operation and status codes, and controller commands for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int Depth   = 16;
  localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW  = $clog2(Depth + 1);
  localparam int SumW    = CountW + 1;
  localparam int DataW   = 32;
  localparam int OccW    = 5;

  typedef enum logic [2:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_BACK   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // latch the incoming item
    logic exec;     // update pointers, issue buffer access
    logic capture;  // take the buffer read data into the result
  } deq_cmd_t;

  // Fold a sum below twice the depth back into the buffer range.
  function automatic logic [AddrW-1:0] wrap_index(input logic [SumW-1:0] s);
    logic [SumW-1:0] t;
    begin
      t = s;
      if (s >= SumW'(Depth)) begin
        t = s - SumW'(Depth);
      end
      return t[AddrW-1:0];
    end
  endfunction

endpackage

FILE: rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read/write address per cycle, registered read data (read-first).
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Sequences one item: accept, execute, read back, hand over the result.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output deq_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_READ;
      S_READ: state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign cmd_o.load    = in_valid_i && in_ready_o;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.capture = (state_q == S_READ);

  // An accepted item is executed on the next cycle.
  a_load_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec)
    else $error("execute did not follow a transfer");

  // Read data is captured right after execution.
  a_exec_capture : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> cmd_o.capture)
    else $error("capture did not follow execute");

  // No new item while a result is pending.
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

endmodule

FILE: rtl/deq_dp.sv
// ----------------------------------------------------------------------------
// Deque datapath
// Head pointer, word count, circular buffer and result registers.
// ----------------------------------------------------------------------------
module deq_dp
  import deq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  deq_cmd_t                cmd_i,
  input  logic [2:0]              kind_i,
  input  logic signed [DataW-1:0] value_i,
  output logic signed [DataW-1:0] popped_value_o,
  output logic [1:0]              status_o,
  output logic [OccW-1:0]         occupancy_o
);

  logic [2:0]        kind_q;
  logic [DataW-1:0]  value_q;
  logic [AddrW-1:0]  head_q, head_d;
  logic [CountW-1:0] count_q, count_d;
  logic [1:0]        status_q, status_d;
  logic              pop_q, pop_d;
  logic [DataW-1:0]  popped_q;

  logic              full, empty;
  logic              ram_we;
  logic [AddrW-1:0]  ram_addr;
  logic [DataW-1:0]  ram_rdata;
  logic [SumW-1:0]   sum_back;
  logic [AddrW-1:0]  head_dec, head_inc;

  assign full     = (count_q == CountW'(Depth));
  assign empty    = (count_q == '0);
  assign sum_back = SumW'(head_q) + SumW'(count_q);
  assign head_dec = (head_q == '0) ? AddrW'(Depth - 1) : head_q - AddrW'(1);
  assign head_inc = wrap_index(SumW'(head_q) + SumW'(1));

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = ST_DONE;
    pop_d    = 1'b0;
    ram_we   = 1'b0;
    ram_addr = head_q;
    unique case (kind_q)
      KIND_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ram_we   = 1'b1;
          ram_addr = wrap_index(sum_back);
          count_d  = count_q + CountW'(1);
        end
      end
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ram_we   = 1'b1;
          ram_addr = head_dec;
          head_d   = head_dec;
          count_d  = count_q + CountW'(1);
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          pop_d    = 1'b1;
          ram_addr = wrap_index(sum_back - SumW'(1));
          count_d  = count_q - CountW'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          pop_d    = 1'b1;
          ram_addr = head_q;
          head_d   = head_inc;
          count_d  = count_q - CountW'(1);
        end
      end
      KIND_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_q    <= pop_d;
    end
    if (cmd_i.capture) begin
      popped_q <= pop_q ? ram_rdata : '0;
    end
  end

  deq_ram #(
    .Width (DataW),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we && cmd_i.exec),
    .addr_i  (ram_addr),
    .wdata_i (value_q),
    .rdata_o (ram_rdata)
  );

  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign occupancy_o    = OccW'(count_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("word count beyond depth");

  // Never write the buffer while it is full.
  a_no_write_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && ram_we) |-> !full)
    else $error("buffer write while full");

  // Never pop while the buffer is empty.
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && pop_d) |-> !empty)
    else $error("pop while empty");

endmodule

FILE: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of 32-bit words in a circular buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries kind_i and value_i: push
//   back, push front, pop back, pop front or clear. Every transfer yields
//   exactly one result on the output channel (out_valid_o/out_ready_i):
//   popped_value_o (zero unless a pop succeeded), status_o (done, pop on
//   empty, push on full dropped) and occupancy_o after the operation.
//   After the input transfer the item is executed and read back before
//   the result is valid. One item is in flight at a time, so an item
//   passes through input transfer, execute, buffer read through the
//   registered RAM port and result transfer before the next is taken.
//   The buffer holds Depth words; a push onto a full queue is dropped.
//   Reset empties the queue and returns to idle; buffer contents are not
//   cleared, as only written entries are ever read.
//   While the receiver stalls the result holds and in_ready_o stays low.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              kind_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] popped_value_o,
  output logic [1:0]              status_o,
  output logic [OccW-1:0]         occupancy_o
);

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  deq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

FILE: dv/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, clear and unused operations into the deque, mirrors the
// circular buffer to predict each result, and checks every result in order
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned MaxIdle    = 14;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned ReportMax  = 10;

  // Kind codes the block decodes as no operation.
  localparam logic [2:0] KindSpareLo = 3'd5;
  localparam logic [2:0] KindSpareHi = 3'd7;

  typedef struct packed {
    logic [DataW-1:0] popped;
    status_e          status;
    logic [OccW-1:0]  occupancy;
  } deq_result_t;

  logic                    clk_i;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [2:0]              kind_i      = KIND_PUSH_BACK;
  logic signed [DataW-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] popped_value_o;
  logic [1:0]              status_o;
  logic [OccW-1:0]         occupancy_o;

  // Mirror of the queue contents.
  logic [DataW-1:0] mirror_slots [Depth];
  int unsigned      mirror_head;
  int unsigned      mirror_fill;

  deq_result_t      pending_results [$];
  int unsigned      mismatch_cnt;
  int unsigned      cycle_cnt;
  int unsigned      gap_max_in;
  int unsigned      stall_max_out;

  double_ended_queue i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Apply one operation to the mirror and return the result it yields.
  function automatic deq_result_t apply_deq_op(input logic [2:0] kind,
                                               input logic [DataW-1:0] word);
    deq_result_t res;
    res.popped = '0;
    res.status = ST_DONE;
    case (kind)
      KIND_PUSH_BACK: begin
        if (mirror_fill >= Depth) begin
          res.status = ST_FULL;
        end else begin
          mirror_slots[(mirror_head + mirror_fill) % Depth] = word;
          mirror_fill++;
        end
      end
      KIND_PUSH_FRONT: begin
        if (mirror_fill >= Depth) begin
          res.status = ST_FULL;
        end else begin
          mirror_head = (mirror_head + Depth - 1) % Depth;
          mirror_slots[mirror_head] = word;
          mirror_fill++;
        end
      end
      KIND_POP_BACK: begin
        if (mirror_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = mirror_slots[(mirror_head + mirror_fill - 1) % Depth];
          mirror_fill--;
        end
      end
      KIND_POP_FRONT: begin
        if (mirror_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = mirror_slots[mirror_head];
          mirror_head = (mirror_head + 1) % Depth;
          mirror_fill--;
        end
      end
      KIND_CLEAR: begin
        mirror_fill = 0;
        mirror_head = 0;
      end
      default: begin
      end
    endcase
    res.occupancy = OccW'(mirror_fill);
    return res;
  endfunction

  // Send one operation; predict its result at the transfer.
  task automatic send_op(input logic [2:0] kind, input logic [DataW-1:0] word);
    int unsigned gap;
    deq_result_t predicted;
    gap = $urandom_range(0, gap_max_in);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= word;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_deq_op(kind, word);
    pending_results = {pending_results, predicted};
  endtask

  // Hold the sender off until every pending result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_kind(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      return KIND_CLEAR;
    end else if (roll < 4) begin
      return 3'($urandom_range(KindSpareLo, KindSpareHi));
    end else if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
  endfunction

  // Empty pops, word extremes at both ends and spare kinds.
  task automatic test_edge_ops();
    gap_max_in    = MaxIdle;
    stall_max_out = MaxIdle;
    send_op(KIND_POP_BACK, $urandom);
    send_op(KIND_POP_FRONT, $urandom);
    send_op(KIND_PUSH_BACK, 32'h7FFF_FFFF);
    send_op(KIND_PUSH_FRONT, 32'h8000_0000);
    send_op(KIND_PUSH_BACK, '0);
    send_op(KIND_PUSH_FRONT, '1);
    for (logic [2:0] k = KindSpareLo; k != 3'd0; k++) begin
      send_op(k, $urandom);
    end
    send_op(KIND_POP_FRONT, $urandom);
    send_op(KIND_POP_BACK, $urandom);
  endtask

  // Fill to the limit, overflow, then clear and pop the empty queue.
  task automatic test_full_boundary();
    while (mirror_fill < Depth) begin
      send_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_word());
    end
    send_op(KIND_PUSH_BACK, $urandom);
    send_op(KIND_PUSH_FRONT, $urandom);
    send_op(KIND_POP_BACK, $urandom);
    send_op(KIND_CLEAR, $urandom);
    send_op(KIND_POP_FRONT, $urandom);
    wait_drained();
  endtask

  // Segments with a drifting push/pop mix so the queue swings between
  // empty and full and the pointers wrap many times.
  task automatic test_random_walk(input int unsigned n_items);
    int unsigned sent;
    int unsigned seg_len;
    int unsigned push_pct;
    sent = 0;
    while (sent < n_items) begin
      seg_len = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      case ($urandom_range(0, 3))
        0: begin
          gap_max_in    = 0;
          stall_max_out = 0;
        end
        1: begin
          gap_max_in    = MaxIdle;
          stall_max_out = MaxIdle;
        end
        2: begin
          gap_max_in    = MaxIdle;
          stall_max_out = 0;
        end
        default: begin
          gap_max_in    = 0;
          stall_max_out = MaxIdle;
        end
      endcase
      repeat (seg_len) begin
        send_op(pick_kind(push_pct), pick_word());
      end
      sent += seg_len;
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
      end
    end
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_streaming(input int unsigned n_items);
    gap_max_in    = 0;
    stall_max_out = 0;
    repeat (n_items) begin
      send_op(pick_kind(50), pick_word());
    end
    wait_drained();
  endtask

  // Result side: stall, accept and check against the oldest prediction.
  initial begin
    int unsigned stall;
    deq_result_t want;
    wait (rst_ni);
    forever begin
      stall = $urandom_range(0, stall_max_out);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ReportMax) begin
          $display("unexpected result: popped %h status %0d occupancy %0d",
                   popped_value_o, status_o, occupancy_o);
        end
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (popped_value_o !== want.popped || status_o !== want.status ||
            occupancy_o !== want.occupancy) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportMax) begin
            $display("mismatch: popped %h/%h status %0d/%0d occupancy %0d/%0d",
                     want.popped, popped_value_o, want.status, status_o,
                     want.occupancy, occupancy_o);
          end
        end
      end
    end
  end

  initial begin
    mirror_head   = 0;
    mirror_fill   = 0;
    mismatch_cnt  = 0;
    cycle_cnt     = 0;
    gap_max_in    = 0;
    stall_max_out = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_ops();
    test_full_boundary();
    test_random_walk(1100);
    test_streaming(125);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
